/* rtl/bpt_pkg.sv */
// ----------------------------------------------------------------------------
// Breakpoint table package
// Shared codes, token type and defaults for the breakpoint table unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bpt_pkg;

	localparam int ENTRIES_DEF   = 256;
	localparam int ADDR_BITS_DEF = 16;

	// input word kinds
	localparam logic [2:0] KIND_SET    = 3'd0;
	localparam logic [2:0] KIND_REMOVE = 3'd1;
	localparam logic [2:0] KIND_FETCH  = 3'd2;
	localparam logic [2:0] KIND_PAUSE  = 3'd3;
	localparam logic [2:0] KIND_CONT   = 3'd4;

	// result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

	// operation carried by the token down the cell row
	typedef enum logic [1:0] {
		OP_LOOK_SET,
		OP_REMOVE,
		OP_FETCH,
		OP_INSERT
	} op_t;

	// token handed from cell to cell
	typedef struct packed {
		logic vld;
		op_t  op;
		logic found;  // match seen, or slot claimed on insert
		logic armed;  // matching entry is enabled
	} tok_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_INSERT,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

/* rtl/bpt_in_if.sv */
// ----------------------------------------------------------------------------
// Breakpoint table input channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpt_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [15:0] addr;
	logic        enable;

	modport source (output valid, kind, addr, enable, input ready);
	modport sink   (input valid, kind, addr, enable, output ready);
endinterface

`default_nettype wire

/* rtl/bpt_out_if.sv */
// ----------------------------------------------------------------------------
// Breakpoint table output channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpt_out_if;
	logic       valid;
	logic       ready;
	logic       hit;
	logic       found;
	logic       stepping_now;
	logic [1:0] status;
	logic [8:0] used_entries;

	modport source (output valid, hit, found, stepping_now, status, used_entries,
		input ready);
	modport sink   (input valid, hit, found, stepping_now, status, used_entries,
		output ready);
endinterface

`default_nettype wire

/* rtl/breakpoint_table_unit_top.sv */
// ----------------------------------------------------------------------------
// Breakpoint table unit
// Debug breakpoint table built as a row of slot cells walked by a token.
// ----------------------------------------------------------------------------
// The unit holds up to ENTRIES distinct breakpoint addresses, each with an
// enable bit, and a stepping flag. One command word is worked at a time: a
// token walks the row of ENTRIES cells, one cell per cycle, for set (present
// address), remove and fetch; a set of a new address with room left walks the
// row twice; pause, continue and unknown kinds skip the row. A finished word
// waits while a result word still held at the output register is not taken.
// The input is taken again as soon as the unit is idle, even while a result
// word still waits at the output register. Writing start_stepping also loads
// the stepping flag at once; the configuration port is ready only while the
// unit is idle. Table contents are cleared by reset, no clearing pass is
// needed.
// ----------------------------------------------------------------------------
`default_nettype none

module breakpoint_table_unit_top #(
	parameter int ENTRIES   = bpt_pkg::ENTRIES_DEF,
	parameter int ADDR_BITS = bpt_pkg::ADDR_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	bpt_in_if.sink      bp_in,
	bpt_out_if.source   bp_out,
	input  wire logic   cfg_valid,
	output      logic   cfg_ready,
	input  wire logic   cfg_data
);

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

	// token row: tok[0] is the head register, tok[ENTRIES] the tail
	bpt_pkg::tok_t tok [0:ENTRIES];

	bpt_pkg::state_t state_q, state_d;

	logic [2:0]           kind_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic                 en_q;
	logic                 found_q;
	logic                 armed_q;
	logic [CNT_W-1:0]     count_q;
	logic                 stepping_q;
	bpt_pkg::tok_t        head_q;

	// output register
	logic                 out_vld_q;
	logic                 out_hit_q;
	logic                 out_found_q;
	logic                 out_step_q;
	logic [1:0]           out_status_q;
	logic [8:0]           out_used_q;

	logic                 accept;
	logic                 chain_kind;
	logic                 need_ins;
	logic                 launch_look;
	logic                 launch_ins;
	logic                 fire;
	bpt_pkg::op_t         look_op;
	logic [ADDR_BITS+15:0] addr_ext;

	// result of the finished word
	logic                 res_hit;
	logic                 res_step;
	logic [1:0]           res_status;
	logic [CNT_W-1:0]     res_count;
	logic [CNT_W+8:0]     res_count_ext;

	// config only between words, so it never meets a result update
	assign cfg_ready = (state_q == bpt_pkg::ST_IDLE);
	assign addr_ext  = {{ADDR_BITS{1'b0}}, bp_in.addr};

	assign accept     = bp_in.valid && bp_in.ready;
	assign chain_kind = (bp_in.kind == bpt_pkg::KIND_SET) ||
	                    (bp_in.kind == bpt_pkg::KIND_REMOVE) ||
	                    (bp_in.kind == bpt_pkg::KIND_FETCH);
	// new address, room left: second pass to claim the lowest free slot
	assign need_ins   = (kind_q == bpt_pkg::KIND_SET) && !tok[ENTRIES].found &&
	                    (count_q != FULL_CNT);

	always_comb begin
		unique case (bp_in.kind)
			bpt_pkg::KIND_SET:    look_op = bpt_pkg::OP_LOOK_SET;
			bpt_pkg::KIND_REMOVE: look_op = bpt_pkg::OP_REMOVE;
			default:              look_op = bpt_pkg::OP_FETCH;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bpt_pkg::ST_IDLE: begin
				if (accept) state_d = chain_kind ? bpt_pkg::ST_LOOK : bpt_pkg::ST_FIN;
			end
			bpt_pkg::ST_LOOK: begin
				if (tok[ENTRIES].vld) state_d = need_ins ? bpt_pkg::ST_INSERT : bpt_pkg::ST_FIN;
			end
			bpt_pkg::ST_INSERT: begin
				if (tok[ENTRIES].vld) state_d = bpt_pkg::ST_FIN;
			end
			bpt_pkg::ST_FIN: begin
				if (!out_vld_q || bp_out.ready) state_d = bpt_pkg::ST_IDLE;
			end
			default: state_d = bpt_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		bp_in.ready = 1'b0;
		launch_look = 1'b0;
		launch_ins  = 1'b0;
		fire        = 1'b0;
		unique case (state_q)
			bpt_pkg::ST_IDLE: begin
				bp_in.ready = 1'b1;
				launch_look = bp_in.valid && chain_kind;
			end
			bpt_pkg::ST_LOOK: begin
				launch_ins = tok[ENTRIES].vld && need_ins;
			end
			bpt_pkg::ST_INSERT: begin
			end
			bpt_pkg::ST_FIN: begin
				fire = !out_vld_q || bp_out.ready;
			end
			default: begin
			end
		endcase
	end

	// result of the word in hand
	always_comb begin
		res_hit    = 1'b0;
		res_step   = stepping_q;
		res_status = bpt_pkg::STATUS_OK;
		res_count  = count_q;
		unique case (kind_q)
			bpt_pkg::KIND_SET: begin
				if (!found_q) begin
					if (count_q == FULL_CNT) res_status = bpt_pkg::STATUS_FULL;
					else                     res_count  = count_q + 1'b1;
				end
			end
			bpt_pkg::KIND_REMOVE: begin
				if (found_q) res_count  = count_q - 1'b1;
				else         res_status = bpt_pkg::STATUS_NOTFOUND;
			end
			bpt_pkg::KIND_FETCH: begin
				res_hit  = found_q && armed_q && !stepping_q;
				res_step = stepping_q | res_hit;
			end
			bpt_pkg::KIND_PAUSE: res_step = 1'b1;
			bpt_pkg::KIND_CONT:  res_step = 1'b0;
			default: begin
			end
		endcase
		res_count_ext = {9'd0, res_count};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bpt_pkg::ST_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			stepping_q <= 1'b1;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			// head token lives one cycle
			if (launch_look) begin
				head_q <= '{vld: 1'b1, op: look_op, found: 1'b0, armed: 1'b0};
			end else if (launch_ins) begin
				head_q <= '{vld: 1'b1, op: bpt_pkg::OP_INSERT, found: 1'b0, armed: 1'b0};
			end else begin
				head_q <= '0;
			end

			if (fire) begin
				out_vld_q <= 1'b1;
			end else if (bp_out.valid && bp_out.ready) begin
				out_vld_q <= 1'b0;
			end

			if (fire) begin
				count_q    <= res_count;
				stepping_q <= res_step;
			end else if (cfg_valid && cfg_ready) begin
				stepping_q <= cfg_data;
			end
		end
	end

	// word payload and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= bp_in.kind;
			addr_q  <= addr_ext[ADDR_BITS-1:0];
			en_q    <= bp_in.enable;
			found_q <= 1'b0;
			armed_q <= 1'b0;
		end else if (state_q == bpt_pkg::ST_LOOK && tok[ENTRIES].vld) begin
			found_q <= tok[ENTRIES].found;
			armed_q <= tok[ENTRIES].armed;
		end
		if (fire) begin
			out_hit_q    <= res_hit;
			out_found_q  <= found_q;
			out_step_q   <= res_step;
			out_status_q <= res_status;
			out_used_q   <= res_count_ext[8:0];
		end
	end

	assign tok[0] = head_q;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		bpt_cell #(
			.ADDR_BITS (ADDR_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[g]),
			.addr    (addr_q),
			.enable  (en_q),
			.tok_out (tok[g+1])
		);
	end

	assign bp_out.valid        = out_vld_q;
	assign bp_out.hit          = out_hit_q;
	assign bp_out.found        = out_found_q;
	assign bp_out.stepping_now = out_step_q;
	assign bp_out.status       = out_status_q;
	assign bp_out.used_entries = out_used_q;

endmodule

`default_nettype wire

/* rtl/bpt_cell.sv */
// ----------------------------------------------------------------------------
// Breakpoint table cell
// One table slot; acts on the passing token and hands it to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bpt_cell #(
	parameter int ADDR_BITS = bpt_pkg::ADDR_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bpt_pkg::tok_t        tok_in,
	input  wire logic [ADDR_BITS-1:0] addr,
	input  wire logic                 enable,
	output      bpt_pkg::tok_t        tok_out
);

	logic                 vld_q;
	logic                 en_q;
	logic [ADDR_BITS-1:0] addr_q;
	bpt_pkg::tok_t        tok_q;
	bpt_pkg::tok_t        tok_d;
	logic                 match;
	logic                 take;

	always_comb begin
		match = vld_q && (addr_q == addr);
		// first free slot claims an insert
		take  = tok_in.vld && (tok_in.op == bpt_pkg::OP_INSERT) && !vld_q && !tok_in.found;
		tok_d       = tok_in;
		tok_d.found = tok_in.found | match | take;
		tok_d.armed = tok_in.armed | (match & en_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			en_q  <= 1'b0;
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
			if (tok_in.vld) begin
				unique case (tok_in.op)
					bpt_pkg::OP_LOOK_SET: begin
						if (match) en_q <= enable;
					end
					bpt_pkg::OP_REMOVE: begin
						if (match) begin
							vld_q <= 1'b0;
							en_q  <= 1'b0;
						end
					end
					bpt_pkg::OP_FETCH: begin
					end
					bpt_pkg::OP_INSERT: begin
						if (take) begin
							vld_q <= 1'b1;
							en_q  <= enable;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// address payload, no reset
	always_ff @(posedge clk) begin
		if (take) addr_q <= addr;
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

/* tb/breakpoint_table_unit_top_tb.sv */
// ----------------------------------------------------------------------------
// Breakpoint table unit testbench
// Drives set, remove, fetch, pause, continue and undefined command words into
// the unit. An in-bench predictor keeps its own copy of the address table and
// the stepping flag. Each result word is checked against the oldest
// prediction. The sender runs in random bursts. The receiver stalls on a
// pattern of its own, with two long hold-offs that back the unit up.
// ----------------------------------------------------------------------------

module breakpoint_table_unit_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import bpt_pkg::*;

	localparam int ENTRIES       = ENTRIES_DEF;
	// a set of a new address walks the cell row twice; leave margin on top
	localparam int SETTLE_CYCLES = 2 * ENTRIES + 16;
	localparam int CYCLE_LIMIT   = 3_000_000;
	localparam int LONG_HOLD     = 3000;

	// command kinds the unit treats as no-ops
	localparam logic [2:0] KIND_RSVD5 = 3'd5;
	localparam logic [2:0] KIND_RSVD6 = 3'd6;
	localparam logic [2:0] KIND_RSVD7 = 3'd7;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] addr;
		logic        enable;
	} cmd_t;

	typedef struct packed {
		logic       hit;
		logic       found;
		logic       stepping_now;
		logic [1:0] status;
		logic [8:0] used_entries;
	} result_t;

	typedef struct {
		cmd_t    cmd;
		result_t res;
	} pending_t;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	// ------------------------------------------------------------------------
	// clock, reset, channels, unit
	// ------------------------------------------------------------------------
	logic clk;
	logic arst_n    = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_data  = 1'b0;
	logic cfg_ready;

	logic drv_valid = 1'b0;
	cmd_t drv_cmd   = '0;
	logic rcv_ready = 1'b0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	bpt_in_if  in_ch ();
	bpt_out_if out_ch ();

	assign in_ch.valid  = drv_valid;
	assign in_ch.kind   = drv_cmd.kind;
	assign in_ch.addr   = drv_cmd.addr;
	assign in_ch.enable = drv_cmd.enable;
	assign out_ch.ready = rcv_ready;

	breakpoint_table_unit_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bp_in     (in_ch),
		.bp_out    (out_ch),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------------
	// predictor state: address table, enables, live bits, count, stepping
	// ------------------------------------------------------------------------
	logic [15:0] bp_addr [ENTRIES];
	logic        bp_en   [ENTRIES];
	logic        bp_live [ENTRIES];
	int unsigned bp_count;
	logic        step_flag;
	logic        step_reset_val;

	// bookkeeping shared by stimulus, driver and monitor
	cmd_t     cmd_q [$];
	pending_t expect_q [$];
	int       issued   = 0;
	int       accepted = 0;
	int       errors   = 0;
	int       n_checked = 0, n_hits = 0, n_full = 0, n_absent = 0, max_used = 0;
	int       cycles   = 0;

	function automatic void clear_table();
		int i;
		for (i = 0; i < ENTRIES; i++) begin
			bp_addr[i] = '0;
			bp_en[i]   = 1'b0;
			bp_live[i] = 1'b0;
		end
		bp_count       = 0;
		step_reset_val = 1'b1;
		step_flag      = 1'b1;
	endfunction

	// Applies one command word to the table copy and returns the result word.
	function automatic result_t bp_apply(cmd_t c);
		result_t r;
		int      i;
		int      slot;
		int      free_idx;
		r        = '0;
		slot     = -1;
		free_idx = -1;
		for (i = 0; i < ENTRIES; i++) begin
			if (slot < 0 && bp_live[i] && bp_addr[i] == c.addr)
				slot = i;
			if (free_idx < 0 && !bp_live[i])
				free_idx = i;
		end
		case (c.kind)
			KIND_SET: begin
				// present address: enable update only, even with the table full
				if (slot >= 0) begin
					r.found     = 1'b1;
					bp_en[slot] = c.enable;
				end else if (bp_count >= ENTRIES || free_idx < 0) begin
					r.status = STATUS_FULL;
				end else begin
					// new address lands in the lowest free slot
					bp_addr[free_idx] = c.addr;
					bp_en[free_idx]   = c.enable;
					bp_live[free_idx] = 1'b1;
					bp_count++;
				end
			end
			KIND_REMOVE: begin
				if (slot >= 0) begin
					r.found       = 1'b1;
					bp_live[slot] = 1'b0;
					bp_en[slot]   = 1'b0;
					bp_addr[slot] = '0;
					if (bp_count > 0)
						bp_count--;
				end else begin
					r.status = STATUS_NOTFOUND;
				end
			end
			KIND_FETCH: begin
				// a match while stepping reports found but never hits
				if (slot >= 0) begin
					r.found = 1'b1;
					if (bp_en[slot] && !step_flag) begin
						r.hit     = 1'b1;
						step_flag = 1'b1;
					end
				end
			end
			KIND_PAUSE: step_flag = 1'b1;
			KIND_CONT:  step_flag = 1'b0;
			default: ;
		endcase
		r.stepping_now = step_flag;
		r.used_entries = 9'(bp_count);
		return r;
	endfunction

	function automatic string fmt_res(result_t r);
		return $sformatf("hit=%0d found=%0d step=%0d status=%0d used=%0d",
			r.hit, r.found, r.stepping_now, r.status, r.used_entries);
	endfunction

	function automatic void note_error(string msg);
		errors++;
		if (errors <= 10)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endfunction

	// ------------------------------------------------------------------------
	// monitor: checks result words, then predicts for accepted command words
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		result_t  got;
		pending_t want;
		cmd_t     c;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got.hit          = out_ch.hit;
				got.found        = out_ch.found;
				got.stepping_now = out_ch.stepping_now;
				got.status       = out_ch.status;
				got.used_entries = out_ch.used_entries;
				if (expect_q.size() == 0) begin
					note_error({"result word with nothing expected: ", fmt_res(got)});
				end else begin
					want = expect_q.pop_front();
					n_checked++;
					if (got !== want.res)
						note_error($sformatf("kind %0d addr %h en %0d: expected %s, got %s",
							want.cmd.kind, want.cmd.addr, want.cmd.enable,
							fmt_res(want.res), fmt_res(got)));
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				c.kind   = in_ch.kind;
				c.addr   = in_ch.addr;
				c.enable = in_ch.enable;
				want.cmd = c;
				want.res = bp_apply(c);
				expect_q.push_back(want);
				accepted++;
				if (want.res.hit)
					n_hits++;
				if (want.res.status == STATUS_FULL)
					n_full++;
				if (want.res.status == STATUS_NOTFOUND)
					n_absent++;
				if (want.res.used_entries > max_used)
					max_used = want.res.used_entries;
			end
		end
	end

	// ------------------------------------------------------------------------
	// driver: bursts of words from cmd_q with random gaps between bursts
	// ------------------------------------------------------------------------
	int acc_seen   = 0;
	int burst_left = 1;
	int gap_left   = 0;

	always @(negedge clk) begin
		logic nxt_valid;
		cmd_t nxt_cmd;
		int   r;
		if (arst_n) begin
			nxt_valid = drv_valid;
			nxt_cmd   = drv_cmd;
			// word taken at the last rising edge
			if (accepted != acc_seen) begin
				acc_seen  = accepted;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (cmd_q.size() > 0) begin
					nxt_cmd   = cmd_q.pop_front();
					nxt_valid = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						r = $urandom_range(0, 99);
						// mostly back to back, now and then long enough for the unit to drain
						if (r < 60)
							gap_left = $urandom_range(0, 2);
						else if (r < 92)
							gap_left = $urandom_range(3, 40);
						else
							gap_left = $urandom_range(100, 600);
					end
				end
			end
			// one nonblocking update per signal per edge
			drv_valid <= nxt_valid;
			drv_cmd   <= nxt_cmd;
		end
	end

	// ------------------------------------------------------------------------
	// receiver: stall pattern that changes mode now and then, plus two long
	// hold-offs so the unit fills its output register and stops taking input
	// ------------------------------------------------------------------------
	rx_mode_t stall_mode = RX_OPEN;
	int       mode_left  = 0;
	int       pat_ctr    = 0;
	int       hold_left  = 0;
	int       hold_marks [$] = '{60, 420};

	always @(negedge clk) begin
		logic nxt;
		if (arst_n) begin
			nxt = 1'b1;
			if (hold_left > 0) begin
				hold_left--;
				nxt = 1'b0;
			end else if (hold_marks.size() > 0 && accepted >= hold_marks[0]) begin
				void'(hold_marks.pop_front());
				hold_left = LONG_HOLD - 1;
				nxt       = 1'b0;
			end else begin
				if (mode_left == 0) begin
					stall_mode = rx_mode_t'($urandom_range(0, 3));
					mode_left  = $urandom_range(20, 400);
				end
				mode_left--;
				pat_ctr++;
				case (stall_mode)
					RX_OPEN:   nxt = 1'b1;
					RX_COIN:   nxt = 1'($urandom_range(0, 1));
					RX_SPARSE: nxt = ($urandom_range(0, 9) != 0);
					default:   nxt = ((pat_ctr % 5) < 3);
				endcase
			end
			rcv_ready <= nxt;
		end
	end

	// run guard
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[%0t] timeout after %0d cycles, %0d words outstanding",
				$realtime, cycles, expect_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	logic [15:0] addr_pool [16];
	logic [15:0] fill_addrs [$];

	function automatic void queue_cmd(logic [2:0] k, logic [15:0] a, logic e);
		cmd_t c;
		c.kind   = k;
		c.addr   = a;
		c.enable = e;
		cmd_q.push_back(c);
		issued++;
	endfunction

	function automatic logic [2:0] pick_kind(int w_set, int w_rm, int w_fetch,
		int w_pause, int w_cont, int w_odd);
		int r;
		r = $urandom_range(0, w_set + w_rm + w_fetch + w_pause + w_cont + w_odd - 1);
		if (r < w_set)
			return KIND_SET;
		r -= w_set;
		if (r < w_rm)
			return KIND_REMOVE;
		r -= w_rm;
		if (r < w_fetch)
			return KIND_FETCH;
		r -= w_fetch;
		if (r < w_pause)
			return KIND_PAUSE;
		r -= w_pause;
		if (r < w_cont)
			return KIND_CONT;
		return KIND_RSVD5 + 3'($urandom_range(0, 2));
	endfunction

	function automatic logic [15:0] rand_addr();
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	function automatic logic [15:0] pool_addr();
		return addr_pool[$urandom_range(0, 15)];
	endfunction

	function automatic logic [15:0] pick_fill();
		return fill_addrs[$urandom_range(0, fill_addrs.size() - 1)];
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	// every command word yields a result, so an empty expectation list means
	// idle; the settle time covers a walk still in flight anyway
	task automatic wait_idle();
		do
			@(negedge clk);
		while (issued != accepted || expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// start_stepping also loads the stepping flag right away
	task automatic write_start_stepping(logic v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		step_reset_val = v;
		step_flag      = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		int          n;
		int          r;
		logic [2:0]  k;
		logic [15:0] a;

		clear_table();
		addr_pool[0] = 16'h0000;
		addr_pool[1] = 16'hFFFF;
		addr_pool[2] = 16'h8000;
		addr_pool[3] = 16'h7FFF;
		addr_pool[4] = 16'h0001;
		addr_pool[5] = 16'h5555;
		addr_pool[6] = 16'hAAAA;
		for (n = 7; n < 16; n++)
			addr_pool[n] = rand_addr();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words, stepping on from reset. Covers empty-table fetch, hit
		// and the stepping it causes, disabled and absent fetches, enable update,
		// remove of an absent address, reinsert, removal of the last entry, and
		// the undefined kinds.
		queue_cmd(KIND_FETCH,  16'h0000, 1'b0);
		queue_cmd(KIND_CONT,   16'h0000, 1'b0);
		queue_cmd(KIND_SET,    16'h0000, 1'b1);
		queue_cmd(KIND_SET,    16'hFFFF, 1'b1);
		queue_cmd(KIND_SET,    16'h8000, 1'b0);
		queue_cmd(KIND_FETCH,  16'hFFFF, 1'b0);
		queue_cmd(KIND_FETCH,  16'hFFFF, 1'b0);
		queue_cmd(KIND_CONT,   16'hFFFF, 1'b1);
		queue_cmd(KIND_FETCH,  16'h8000, 1'b1);
		queue_cmd(KIND_FETCH,  16'h1234, 1'b1);
		queue_cmd(KIND_SET,    16'h8000, 1'b1);
		queue_cmd(KIND_FETCH,  16'h8000, 1'b0);
		queue_cmd(KIND_PAUSE,  16'h8000, 1'b0);
		queue_cmd(KIND_CONT,   16'h0000, 1'b0);
		queue_cmd(KIND_REMOVE, 16'h1234, 1'b0);
		queue_cmd(KIND_REMOVE, 16'h0000, 1'b1);
		queue_cmd(KIND_FETCH,  16'h0000, 1'b0);
		queue_cmd(KIND_SET,    16'h0000, 1'b0);
		queue_cmd(KIND_RSVD5,  16'h5555, 1'b1);
		queue_cmd(KIND_RSVD7,  16'hAAAA, 1'b0);
		queue_cmd(KIND_REMOVE, 16'hFFFF, 1'b0);
		queue_cmd(KIND_FETCH,  16'h7FFF, 1'b1);
		queue_cmd(KIND_REMOVE, 16'h8000, 1'b0);
		queue_cmd(KIND_REMOVE, 16'h0000, 1'b0);
		queue_cmd(KIND_RSVD6,  16'h0000, 1'b1);
		wait_idle();

		// Small address pool, stepping cleared: lots of found, hit and not-found
		// traffic.
		write_start_stepping(1'b0);
		for (n = 0; n < 180; n++) begin
			k = pick_kind(25, 15, 35, 7, 13, 5);
			a = ($urandom_range(0, 99) < 85) ? pool_addr() : rand_addr();
			queue_cmd(k, a, rand_bit());
		end
		wait_idle();

		// Fill the table past its size with fresh addresses, stepping set; a
		// continue and a fetch now and then so hits still occur.
		write_start_stepping(1'b1);
		for (n = 0; n < 285; n++) begin
			a = rand_addr();
			fill_addrs.push_back(a);
			queue_cmd(KIND_SET, a, ($urandom_range(0, 3) != 0));
			if (n % 9 == 4) begin
				queue_cmd(KIND_CONT, rand_addr(), rand_bit());
				queue_cmd(KIND_FETCH, pick_fill(), rand_bit());
			end
		end
		// table is full here: enable updates still go through, new sets bounce
		for (n = 0; n < 24; n++) begin
			r = n % 4;
			if (r == 0)
				queue_cmd(KIND_SET, pick_fill(), rand_bit());
			else if (r == 1)
				queue_cmd(KIND_SET, rand_addr(), rand_bit());
			else if (r == 2)
				queue_cmd(KIND_CONT, rand_addr(), rand_bit());
			else
				queue_cmd(KIND_FETCH, pick_fill(), rand_bit());
		end
		wait_idle();

		// Drain from full: remove-heavy mix over filled addresses, with new sets
		// taking the freed slots.
		write_start_stepping(1'b0);
		for (n = 0; n < 150; n++) begin
			k = pick_kind(20, 35, 30, 5, 7, 3);
			r = $urandom_range(0, 99);
			if (r < 70)
				a = pick_fill();
			else if (r < 90)
				a = pool_addr();
			else
				a = rand_addr();
			queue_cmd(k, a, rand_bit());
		end
		wait_idle();

		if (expect_q.size() != 0)
			note_error($sformatf("%0d result words never arrived", expect_q.size()));

		$display("Checked %0d result words from %0d command words: %0d hits, %0d full, %0d not found.",
			n_checked, accepted, n_hits, n_full, n_absent);
		$display("start_stepping run at both values; table held up to %0d entries; %0d errors.",
			max_used, errors);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* breakpoint_table_unit_top.f */
rtl/bpt_pkg.sv
rtl/bpt_in_if.sv
rtl/bpt_out_if.sv
rtl/bpt_cell.sv
rtl/breakpoint_table_unit_top.sv
tb/breakpoint_table_unit_top_tb.sv
